### rtl/core/mpfg_pkg.sv
// Package: shared types and constants for the PWM frame generator.
`timescale 1ns / 1ps
`default_nettype none

package mpfg_pkg;

    localparam int LEVEL_W      = 4;
    localparam int LEVEL_INPUTS = 9;
    localparam int BITS_W       = 9;
    localparam int INDEX_W      = 4;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_8;
        logic [LEVEL_W-1:0] level_7;
        logic [LEVEL_W-1:0] level_6;
        logic [LEVEL_W-1:0] level_5;
        logic [LEVEL_W-1:0] level_4;
        logic [LEVEL_W-1:0] level_3;
        logic [LEVEL_W-1:0] level_2;
        logic [LEVEL_W-1:0] level_1;
        logic [LEVEL_W-1:0] level_0;
    } level_map_t;

    typedef struct packed {
        logic [BITS_W-1:0]  frame_bits;
        logic [INDEX_W-1:0] frame_index;
        logic               last_frame;
    } frame_t;

    // levels as an indexable row; the front end zeroes unused motors before the push
    typedef logic [LEVEL_INPUTS-1:0][LEVEL_W-1:0] level_arr_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

### rtl/core/mpfg_front.sv
// Front end: takes a map transfer, masks motors beyond the count, pushes to the queue.
`timescale 1ns / 1ps
`default_nettype none

module mpfg_front #(
    parameter int MOTOR_COUNT = 9
) (
    input  wire logic                  start,
    input  wire mpfg_pkg::level_map_t  level_map,
    input  wire mpfg_pkg::q_status_t   q_status,
    output logic                       busy,
    output logic                       push,
    output mpfg_pkg::level_arr_t       push_data
);
    import mpfg_pkg::*;

    level_arr_t raw;

    assign raw = {level_map.level_8, level_map.level_7, level_map.level_6,
                  level_map.level_5, level_map.level_4, level_map.level_3,
                  level_map.level_2, level_map.level_1, level_map.level_0};

    assign busy = q_status.full;
    assign push = start && !q_status.full;

    always_comb
    begin
        for (int m = 0; m < LEVEL_INPUTS; m++)
        begin
            push_data[m] = (m < MOTOR_COUNT) ? raw[m] : '0;
        end
    end

endmodule

`default_nettype wire

### rtl/core/mpfg_queue.sv
// Two-entry queue of masked level maps between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module mpfg_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire mpfg_pkg::level_arr_t  push_data,
    input  wire logic                  pop,
    output mpfg_pkg::level_arr_t       head_data,
    output mpfg_pkg::q_status_t        q_status
);
    import mpfg_pkg::*;

    level_arr_t          entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data      = entries_reg[rd_ptr_reg];
    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> !pop)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

### rtl/core/mpfg_back.sv
// Back end: steps through the frames of the head map, one registered frame per cycle while the queue holds a map.
`timescale 1ns / 1ps
`default_nettype none

module mpfg_back #(
    parameter int FRAMES_PER_CYCLE = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mpfg_pkg::level_arr_t  head_data,
    input  wire mpfg_pkg::q_status_t   q_status,
    output logic                       pop,
    output mpfg_pkg::frame_t           frame,
    output logic                       frame_valid
);
    import mpfg_pkg::*;

    localparam int CNT_W = (FRAMES_PER_CYCLE > 1) ? $clog2(FRAMES_PER_CYCLE) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAMES_PER_CYCLE - 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              valid_reg, valid_next;
    frame_t            frame_reg, frame_next;
    logic [INDEX_W-1:0] idx;
    logic              is_last;
    logic              work;

    assign work    = !q_status.empty;
    assign idx     = INDEX_W'(cnt_reg);
    assign is_last = (cnt_reg == LAST_CNT);
    assign pop     = work && is_last;

    always_comb
    begin
        cnt_next   = cnt_reg;
        valid_next = work;
        if (work)
        begin
            cnt_next = is_last ? '0 : cnt_reg + 1'b1;
        end
        frame_next.frame_index = idx;
        frame_next.last_frame  = is_last;
        for (int m = 0; m < LEVEL_INPUTS; m++)
        begin
            frame_next.frame_bits[m] = !is_last && (head_data[m] > idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign frame       = frame_reg;
    assign frame_valid = valid_reg;

`ifndef SYNTHESIS
    a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame.last_frame) |-> (frame.frame_bits == '0))
        else $error("final frame not blank");
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |->
            (frame.last_frame == (frame.frame_index == INDEX_W'(FRAMES_PER_CYCLE - 1))))
        else $error("last flag disagrees with index");
    a_cycle_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && !frame.last_frame) |=>
            (frame_valid && (frame.frame_index == $past(frame.frame_index) + 1'b1)))
        else $error("frame cycle broken");
    a_start_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame.last_frame) |=>
            (!frame_valid || (frame.frame_index == '0)))
        else $error("new cycle not starting at frame zero");
`endif

endmodule

`default_nettype wire

### rtl/core/multichannel_pwm_frame_generator_core.sv
// Top level: multichannel PWM frame generator core.
`timescale 1ns / 1ps
`default_nettype none

// One intensity map in, one full PWM cycle of FRAMES_PER_CYCLE frame words
// out, a frame per clock while a map is queued. A map transfers at a
// rising edge with start high and busy low. Frames appear on frame with
// frame_valid high for exactly one cycle each; the receiver cannot hold
// them off, so capture every strobe. In frame f bit m is set when level m
// exceeds f; the final frame of each cycle is always blank and carries
// last_frame. Motors at or above MOTOR_COUNT read as off. The first frame
// of a map strobes once the map has passed through the queue and the back
// end's frame register. The back end's frame counter emits one frame per
// cycle while the queue holds a map; a two-entry queue lets the next map
// transfer while the current one is still being played out, and busy
// rises only when both entries are held. No state survives between maps.
module multichannel_pwm_frame_generator_core #(
    parameter int MOTOR_COUNT      = 9,
    parameter int FRAMES_PER_CYCLE = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire mpfg_pkg::level_map_t  level_map,
    output mpfg_pkg::frame_t           frame,
    output logic                       frame_valid
);
    import mpfg_pkg::*;

    level_arr_t push_data;
    level_arr_t head_data;
    q_status_t  q_status;
    logic       push;
    logic       pop;

    // front: accept and mask
    mpfg_front #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_front (
        .start     (start),
        .level_map (level_map),
        .q_status  (q_status),
        .busy      (busy),
        .push      (push),
        .push_data (push_data)
    );

    // decoupling queue
    mpfg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .q_status  (q_status)
    );

    // back: frame sequencer with registered output
    mpfg_back #(
        .FRAMES_PER_CYCLE (FRAMES_PER_CYCLE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_data   (head_data),
        .q_status    (q_status),
        .pop         (pop),
        .frame       (frame),
        .frame_valid (frame_valid)
    );

endmodule

`default_nettype wire

### bench/pwm_frame_checker.sv
// Frame checker: predicts each PWM cycle from the accepted level map and compares frames.
`timescale 1ns / 1ps

module pwm_frame_checker #(
    parameter int MOTOR_COUNT      = 9,
    parameter int FRAMES_PER_CYCLE = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  mpfg_pkg::level_map_t level_map,
    input  mpfg_pkg::frame_t     frame,
    input  logic                 frame_valid,
    output int                   mismatches,
    output int                   pending,
    output int                   frames_seen
);
    import mpfg_pkg::*;

    frame_t expected_frames[$];
    int     error_total = 0;
    int     frame_total = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] frame check: %s", $time, msg);
        error_total++;
    endtask

    // One full PWM cycle for a map; the closing frame is always blank.
    function automatic void predict_cycle(input level_map_t map);
        level_arr_t levels;
        frame_t     fr;
        levels = level_arr_t'(map);
        for (int f = 0; f < FRAMES_PER_CYCLE; f++) begin
            fr.frame_index = f[INDEX_W-1:0];
            fr.last_frame  = (f == FRAMES_PER_CYCLE - 1);
            fr.frame_bits  = '0;
            if (!fr.last_frame) begin
                for (int m = 0; m < LEVEL_INPUTS && m < MOTOR_COUNT && m < BITS_W; m++) begin
                    if (int'(levels[m]) > f)
                        fr.frame_bits[m] = 1'b1;
                end
            end
            expected_frames.push_back(fr);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        frame_t want;
        if (!rst_n) begin
            expected_frames.delete();
            pending <= 0;
        end else begin
            if (frame_valid) begin
                frame_total++;
                if (expected_frames.size() == 0) begin
                    report_mismatch($sformatf("unexpected frame bits=%03h index=%0d last=%0b",
                                              frame.frame_bits, frame.frame_index,
                                              frame.last_frame));
                end else begin
                    want = expected_frames.pop_front();
                    if (frame.frame_bits !== want.frame_bits)
                        report_mismatch($sformatf("frame %0d bits got %03h want %03h",
                                                  want.frame_index, frame.frame_bits,
                                                  want.frame_bits));
                    if (frame.frame_index !== want.frame_index)
                        report_mismatch($sformatf("frame_index got %0d want %0d",
                                                  frame.frame_index, want.frame_index));
                    if (frame.last_frame !== want.last_frame)
                        report_mismatch($sformatf("frame %0d last_frame got %0b want %0b",
                                                  want.frame_index, frame.last_frame,
                                                  want.last_frame));
                end
            end
            if (start && !busy)
                predict_cycle(level_map);
            pending <= expected_frames.size();
        end
        mismatches  <= error_total;
        frames_seen <= frame_total;
    end

endmodule

### bench/multichannel_pwm_frame_generator_core_tb.sv
// Testbench top: drives level maps into the PWM frame generator and gives the verdict.
`timescale 1ns / 1ps

module multichannel_pwm_frame_generator_core_tb;
    import mpfg_pkg::*;

    localparam int MOTORS      = 9;
    localparam int FRAMES      = 10;
    localparam int RANDOM_MAPS = 350;
    // Worst case is roughly 365 maps each behind the longest random gap plus
    // its own frames; allow several times that.
    localparam int CYCLE_LIMIT = 100000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    level_map_t level_map;
    frame_t     frame;
    logic       frame_valid;

    int mismatches;
    int pending;
    int frames_seen;
    int maps_sent   = 0;
    int directed    = 0;
    int cycle_count = 0;

    // 2 ns period
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    multichannel_pwm_frame_generator_core #(
        .MOTOR_COUNT      (MOTORS),
        .FRAMES_PER_CYCLE (FRAMES)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .level_map   (level_map),
        .frame       (frame),
        .frame_valid (frame_valid)
    );

    // Checker sits beside the core, watching both sides of it.
    pwm_frame_checker #(
        .MOTOR_COUNT      (MOTORS),
        .FRAMES_PER_CYCLE (FRAMES)
    ) u_frame_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .level_map   (level_map),
        .frame       (frame),
        .frame_valid (frame_valid),
        .mismatches  (mismatches),
        .pending     (pending),
        .frames_seen (frames_seen)
    );

    // Watchdog: a hung handshake or missing frames ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d frames outstanding", cycle_count, pending);
            $display("multichannel_pwm_frame_generator_core: mismatch");
            $finish;
        end
    end

    // Every motor at the same level.
    function automatic level_map_t uniform_map(input int lvl);
        level_arr_t arr;
        for (int m = 0; m < LEVEL_INPUTS; m++)
            arr[m] = lvl[LEVEL_W-1:0];
        return level_map_t'(arr);
    endfunction

    // Motor m gets (m + offset) mod 16, so nine distinct duties per map.
    function automatic level_map_t ramp_map(input int offset);
        level_arr_t arr;
        for (int m = 0; m < LEVEL_INPUTS; m++)
            arr[m] = LEVEL_W'((m + offset) % 16);
        return level_map_t'(arr);
    endfunction

    // One motor at lvl, the rest off.
    function automatic level_map_t single_map(input int motor, input int lvl);
        level_arr_t arr;
        arr = '0;
        arr[motor] = lvl[LEVEL_W-1:0];
        return level_map_t'(arr);
    endfunction

    // Mostly flat random levels; a quarter of maps lean on the boundary values
    // around the frame thresholds (0, 1, 8, 9, 10, 15).
    function automatic level_map_t random_map();
        logic [35:0] raw;
        level_arr_t  arr;
        int          edge_vals[6];
        edge_vals = '{0, 1, 8, 9, 10, 15};
        raw[31:0]  = $urandom;
        raw[35:32] = 4'($urandom_range(0, 15));
        arr = level_arr_t'(raw);
        if ($urandom_range(0, 3) == 0)
        begin
            for (int m = 0; m < LEVEL_INPUTS; m++)
                if ($urandom_range(0, 1) == 1)
                    arr[m] = LEVEL_W'(edge_vals[$urandom_range(0, 5)]);
        end
        return level_map_t'(arr);
    endfunction

    // Mostly back-to-back, some short gaps, the odd long one.
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Present a map and hold it until the transfer edge (start high, busy low).
    task automatic send_map(input level_map_t map);
        @(negedge clk);
        start     <= 1'b1;
        level_map <= map;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        maps_sent++;
    endtask

    // Drop start for a number of cycles; data lines carry junk meanwhile.
    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            start     <= 1'b0;
            level_map <= random_map();
            repeat (cycles - 1)
                @(negedge clk);
        end
    endtask

    // Hold off until every predicted frame has been seen.
    task automatic wait_drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        start     = 1'b0;
        level_map = '0;
        rst_n     = 1'b0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        idle_gap(2);

        // Directed: all off, saturated, exactly at and either side of the
        // top threshold, a ramp across every level value, single motors at each
        // end of the word and in the middle, checkerboards and a counting pattern.
        send_map(uniform_map(0));
        send_map(uniform_map(15));
        send_map(uniform_map(9));
        send_map(uniform_map(8));
        send_map(uniform_map(10));
        send_map(uniform_map(1));
        send_map(ramp_map(0));
        send_map(ramp_map(7));
        send_map(ramp_map(12));
        send_map(single_map(0, 15));
        send_map(single_map(8, 9));
        send_map(single_map(4, 5));
        send_map(level_map_t'(36'hF0F0F0F0F));
        send_map(level_map_t'(36'h0F0F0F0F0));
        send_map(level_map_t'(36'h123456789));
        directed = maps_sent;
        wait_drain();

        // Random maps: every sixty starts with a burst of fifteen with no
        // gaps, so the two-entry queue fills and busy gets exercised.
        for (int i = 0; i < RANDOM_MAPS; i++)
        begin
            if (i == 120 || i == 260)
                wait_drain();
            if (i % 60 >= 15)
                idle_gap(random_gap());
            send_map(random_map());
        end

        wait_drain();
        // Room for any stray frame after the last expected one.
        repeat (2 * FRAMES)
            @(posedge clk);

        $display("covered %0d level maps (%0d directed) and %0d frames", maps_sent, directed,
                 frames_seen);
        $display("with back-to-back transfers, random gaps and full drain pauses");
        if (mismatches == 0)
            $display("multichannel_pwm_frame_generator_core: match");
        else
            $display("multichannel_pwm_frame_generator_core: mismatch");
        $finish;
    end

endmodule
